[rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// concurrent check, disabled while reset is asserted
`define PB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent check that also holds during reset
`define PB_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PB_ASSERT(lbl, clk, rst_n, prop, msg)
`define PB_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[rtl/pbchs_pkg.sv]
// Shared types and constants for the partition block to CHS translator
package pbchs_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_HEADS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPT   = 3'd5;
    localparam logic [4:0] HEADS_RESET = 5'd16;
    localparam logic [7:0] SPT_RESET   = 8'd63;

    // field widths
    localparam int SEL_W   = 2;
    localparam int ABS_W   = 32;
    localparam int COUNT_W = 7;
    localparam int CYL_W   = 16;
    localparam int HEAD_W  = 4;
    localparam int SEC_W   = 8;

    // divider: divisor up to 31 heads * 255 sectors needs 13 bits
    localparam int PC_W   = 13;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEPS_CYL  = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_HEAD = 6'd13;

    // controller to datapath
    typedef struct packed {
        logic load;           // latch request, add start, check range
        logic div_cyl_start;  // divide absolute sector by sectors per cylinder
        logic div_head_start; // divide remainder by sectors per track
        logic pos_load;       // load head and sector counters
        logic emit;           // write one translated result
        logic emit_err;       // write the out-of-range result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic range_ok;
        logic count_zero;
        logic div_done;
        logic out_free;
        logic last_one;
    } sts_t;

endpackage

[rtl/pbchs_if.sv]
// Channel interfaces: request, result and configuration write
interface pbchs_req_if;
    logic                            valid;
    logic                            ready;
    logic [pbchs_pkg::SEL_W-1:0]     partition_sel;
    logic [pbchs_pkg::ABS_W-1:0]     rel_sector;
    logic [pbchs_pkg::COUNT_W-1:0]   sector_count;

    modport source (output valid, partition_sel, rel_sector, sector_count, input ready);
    modport sink   (input valid, partition_sel, rel_sector, sector_count, output ready);
endinterface

interface pbchs_res_if;
    logic                            valid;
    logic                            ready;
    logic [pbchs_pkg::CYL_W-1:0]     cylinder;
    logic [pbchs_pkg::HEAD_W-1:0]    head;
    logic [pbchs_pkg::SEC_W-1:0]     sector_num;
    logic                            status;
    logic                            last;

    modport source (output valid, cylinder, head, sector_num, status, last, input ready);
    modport sink   (input valid, cylinder, head, sector_num, status, last, output ready);
endinterface

interface pbchs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pbchs_pkg::CFG_IDX_W-1:0]     index;
    logic [pbchs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pbchs_ctrl.sv]
// Request sequencer: load, range check, two divisions, result stream
`include "assert_macros.svh"

module pbchs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pbchs_pkg::sts_t   sts,
    output pbchs_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_DIV2  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_ERR   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.range_ok)
                    state_next = S_ERR;
                else if (sts.count_zero)
                    state_next = S_IDLE;
                else
                begin
                    cmd.div_cyl_start = 1'b1;
                    state_next        = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (sts.div_done)
                begin
                    cmd.div_head_start = 1'b1;
                    state_next         = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (sts.div_done)
                begin
                    cmd.pos_load = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_one)
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // a result is only written into a free output register
    `PB_ASSERT(a_emit_slot, clk, rst_n, (cmd.emit || cmd.emit_err) |-> sts.out_free, "emit into busy output")
    // the sequencer waits for the divider
    `PB_ASSERT(a_div_wait, clk, rst_n, (state_reg == S_DIV1 && !sts.div_done) |=> (state_reg == S_DIV1), "left divide early")
    // an error request ends with its single result
    `PB_ASSERT(a_err_idle, clk, rst_n, cmd.emit_err |=> (state_reg == S_IDLE), "error result not final")

endmodule

[rtl/pbchs_dp.sv]
// Datapath: config registers, range check, radix-2 divider, CHS counters, output register
`include "assert_macros.svh"

module pbchs_dp #(
    parameter int NUM_PARTITIONS = 4,
    parameter int MAX_RUN        = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pbchs_pkg::cmd_t                    cmd,
    output pbchs_pkg::sts_t                    sts,
    input  logic [pbchs_pkg::SEL_W-1:0]        req_partition_sel,
    input  logic [pbchs_pkg::ABS_W-1:0]        req_rel_sector,
    input  logic [pbchs_pkg::COUNT_W-1:0]      req_sector_count,
    pbchs_cfg_if.sink                          cfg,
    pbchs_res_if.source                        res
);

    localparam int IW    = pbchs_pkg::CFG_IDX_W;
    localparam int SW    = pbchs_pkg::SEL_W;
    localparam int AW    = pbchs_pkg::ABS_W;
    localparam int CW    = pbchs_pkg::COUNT_W;
    localparam int PW    = pbchs_pkg::PC_W;
    localparam int TW    = pbchs_pkg::STEP_W;
    localparam int YW    = pbchs_pkg::CYL_W;
    localparam int CNT_W = $clog2(MAX_RUN + 1);

    // configuration registers
    logic [pbchs_pkg::CFG_DATA_W-1:0] region_reg [NUM_PARTITIONS];
    logic [4:0]                       heads_reg;
    logic [7:0]                       spt_reg;

    // request and walk state
    logic [AW-1:0]    abs_reg;
    logic             range_ok_reg;
    logic [CNT_W-1:0] remain_reg;
    logic [PW-1:0]    per_cyl_reg;

    // divider
    logic [AW-1:0]                    qd_reg;
    logic [PW-1:0]                    rem_reg;
    logic [PW-1:0]                    dvs_reg;
    logic [pbchs_pkg::STEP_W-1:0]     step_reg;

    // position counters
    logic [pbchs_pkg::CYL_W-1:0] cyl_reg;
    logic [4:0]                  head_reg;
    logic [7:0]                  sec_reg;

    // output register
    logic                           res_valid_reg;
    logic [pbchs_pkg::CYL_W-1:0]    res_cyl_reg;
    logic [pbchs_pkg::HEAD_W-1:0]   res_head_reg;
    logic [pbchs_pkg::SEC_W-1:0]    res_sec_reg;
    logic                           res_status_reg;
    logic                           res_last_reg;

    logic [pbchs_pkg::CFG_DATA_W-1:0] sel_region;
    logic                             sel_hit;
    logic [4:0]                       heads_eff;
    logic [7:0]                       spt_eff;
    logic [CNT_W-1:0]                 count_eff;
    logic [PW:0]                      trial;
    logic [PW:0]                      diff;
    logic                             ge;
    logic [PW-1:0]                    rem_step;
    logic                             sec_wrap;
    logic                             head_wrap;

    assign cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PARTITIONS; p++)
                region_reg[p] <= '0;
            heads_reg <= pbchs_pkg::HEADS_RESET;
            spt_reg   <= pbchs_pkg::SPT_RESET;
        end
        else if (cfg.valid)
        begin
            for (int p = 0; p < NUM_PARTITIONS; p++)
                if (cfg.index == IW'(p))
                    region_reg[p] <= cfg.data;
            if (cfg.index == pbchs_pkg::REG_HEADS)
                heads_reg <= cfg.data[4:0];
            if (cfg.index == pbchs_pkg::REG_SPT)
                spt_reg <= cfg.data[7:0];
        end
    end

    // partition select; a selector past the table misses
    always_comb
    begin
        sel_hit    = 1'b0;
        sel_region = '0;
        for (int p = 0; p < NUM_PARTITIONS; p++)
            if (req_partition_sel == SW'(p))
            begin
                sel_hit    = 1'b1;
                sel_region = region_reg[p];
            end
    end

    // geometry with zero taken as one, run length saturated
    assign heads_eff = (heads_reg == 5'd0) ? 5'd1 : heads_reg;
    assign spt_eff   = (spt_reg == 8'd0) ? 8'd1 : spt_reg;
    assign count_eff = (req_sector_count > CW'(MAX_RUN)) ? CNT_W'(MAX_RUN)
                                                         : CNT_W'(req_sector_count);

    // one restoring-division step
    assign trial    = {rem_reg, qd_reg[AW-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign rem_step = ge ? diff[PW-1:0] : trial[PW-1:0];

    assign sec_wrap  = (sec_reg == spt_eff - 8'd1);
    assign head_wrap = (head_reg == heads_eff - 5'd1);

    // request latch, range check and run counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_ok_reg <= 1'b0;
            remain_reg   <= '0;
        end
        else if (cmd.load)
        begin
            range_ok_reg <= sel_hit && (req_rel_sector < sel_region[63:32]);
            remain_reg   <= count_eff;
        end
        else if (cmd.emit)
            remain_reg <= remain_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            per_cyl_reg <= PW'(heads_eff) * PW'(spt_eff);
    end

    // divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.div_cyl_start)
            step_reg <= pbchs_pkg::STEPS_CYL;
        else if (cmd.div_head_start)
            step_reg <= pbchs_pkg::STEPS_HEAD;
        else if (step_reg != '0)
            step_reg <= step_reg - TW'(1);
    end

    // divider data: cylinder pass on the absolute sector, head pass on its remainder
    always_ff @(posedge clk)
    begin
        if (cmd.div_cyl_start)
        begin
            qd_reg  <= abs_reg;
            rem_reg <= '0;
            dvs_reg <= per_cyl_reg;
        end
        else if (cmd.div_head_start)
        begin
            qd_reg  <= {rem_reg, (AW - PW)'(0)};
            rem_reg <= '0;
            dvs_reg <= PW'(spt_eff);
        end
        else if (step_reg != '0)
        begin
            qd_reg  <= {qd_reg[AW-2:0], ge};
            rem_reg <= rem_step;
        end
    end

    // absolute sector and CHS position, stepped once per result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            abs_reg <= sel_region[31:0] + req_rel_sector;
        else if (cmd.emit)
            abs_reg <= abs_reg + AW'(1);

        if (cmd.div_head_start)
            cyl_reg <= qd_reg[pbchs_pkg::CYL_W-1:0];
        if (cmd.pos_load)
        begin
            head_reg <= qd_reg[4:0];
            sec_reg  <= rem_reg[7:0];
        end
        else if (cmd.emit)
        begin
            if (abs_reg == '1)
            begin
                // address wraps to sector zero
                cyl_reg  <= '0;
                head_reg <= '0;
                sec_reg  <= '0;
            end
            else if (sec_wrap)
            begin
                sec_reg <= '0;
                if (head_wrap)
                begin
                    head_reg <= '0;
                    cyl_reg  <= cyl_reg + YW'(1);
                end
                else
                    head_reg <= head_reg + 5'd1;
            end
            else
                sec_reg <= sec_reg + 8'd1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.emit || cmd.emit_err)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_cyl_reg    <= cyl_reg;
            res_head_reg   <= head_reg[pbchs_pkg::HEAD_W-1:0];
            res_sec_reg    <= sec_reg + 8'd1;
            res_status_reg <= 1'b0;
            res_last_reg   <= (remain_reg == CNT_W'(1));
        end
        else if (cmd.emit_err)
        begin
            res_cyl_reg    <= '0;
            res_head_reg   <= '0;
            res_sec_reg    <= '0;
            res_status_reg <= 1'b1;
            res_last_reg   <= 1'b1;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.cylinder   = res_cyl_reg;
    assign res.head       = res_head_reg;
    assign res.sector_num = res_sec_reg;
    assign res.status     = res_status_reg;
    assign res.last       = res_last_reg;

    // status to the sequencer
    assign sts.range_ok   = range_ok_reg;
    assign sts.count_zero = (remain_reg == '0);
    assign sts.div_done   = (step_reg == '0);
    assign sts.out_free   = !res_valid_reg || res.ready;
    assign sts.last_one   = (remain_reg == CNT_W'(1));

    `PB_ASSERT_NR(a_step_bound, clk, (!rst_n || step_reg <= pbchs_pkg::STEPS_CYL), "divider step count out of range")
    `PB_ASSERT(a_remain_dec, clk, rst_n, cmd.emit |=> (remain_reg == $past(remain_reg) - CNT_W'(1)), "run count not stepped")
    `PB_ASSERT(a_res_load, clk, rst_n, (cmd.emit || cmd.emit_err) |=> res_valid_reg, "result not presented")

endmodule

[rtl/partition_block_to_chs_core.sv]
// Top level of the partition block to CHS translator
//
// Each request is latched and has the partition start added, then its range
// is checked, then it takes two passes of a one-bit-per-cycle divider (the
// cylinder pass, then the head and sector pass); results then leave at one
// per cycle while the result side is ready. A new request is taken as soon
// as the last result of the previous run sits in the output register.
// Partition and geometry registers are written through the cfg channel,
// which is always ready; the user must write them only while no request
// is in flight, as the block itself does not enforce this.
module partition_block_to_chs_core #(
    parameter int NUM_PARTITIONS = 4,
    parameter int MAX_RUN        = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    pbchs_req_if.sink   req,
    pbchs_res_if.source res,
    pbchs_cfg_if.sink   cfg
);

    pbchs_pkg::cmd_t cmd;
    pbchs_pkg::sts_t sts;

    // sequencer
    pbchs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    pbchs_dp #(
        .NUM_PARTITIONS (NUM_PARTITIONS),
        .MAX_RUN        (MAX_RUN)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_partition_sel (req.partition_sel),
        .req_rel_sector    (req.rel_sector),
        .req_sector_count  (req.sector_count),
        .cfg               (cfg),
        .res               (res)
    );

endmodule

[tb/sv/pbchs_chs_checker.sv]
`timescale 1ns / 100ps
// Result checker for the CHS translator: follows register writes, predicts results, compares
module pbchs_chs_checker #(
    parameter int NUM_PARTITIONS = 4,
    parameter int MAX_RUN        = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    pbchs_req_if        req,
    pbchs_res_if        res,
    pbchs_cfg_if        cfg,
    output int unsigned pending,
    output int unsigned errors
);

    // package constants used here
    localparam int CFG_DATA_W = pbchs_pkg::CFG_DATA_W;
    localparam int SEL_W      = pbchs_pkg::SEL_W;
    localparam int ABS_W      = pbchs_pkg::ABS_W;
    localparam int COUNT_W    = pbchs_pkg::COUNT_W;
    localparam int CYL_W      = pbchs_pkg::CYL_W;
    localparam int HEAD_W     = pbchs_pkg::HEAD_W;
    localparam int SEC_W      = pbchs_pkg::SEC_W;

    typedef struct packed {
        logic [CYL_W-1:0]  cylinder;
        logic [HEAD_W-1:0] head;
        logic [SEC_W-1:0]  sector_num;
        logic              status;
        logic              last;
    } chs_result_t;

    // shadow copy of the register file
    logic [CFG_DATA_W-1:0] region_map [1 << SEL_W];
    logic [4:0]            heads_cfg;
    logic [7:0]            spt_cfg;

    // translations still owed by the block, oldest first
    chs_result_t chs_due [$];
    int unsigned due_cnt  = 0;
    int unsigned fail_cnt = 0;

    assign pending = due_cnt;
    assign errors  = fail_cnt;

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        fail_cnt++;
    endtask

    // expand one accepted request into the results it must produce
    function automatic void translate_run(input logic [SEL_W-1:0] sel,
                                          input logic [ABS_W-1:0] rel,
                                          input logic [COUNT_W-1:0] cnt);
        chs_result_t      r;
        logic [ABS_W-1:0] base_lba, lba, per_cyl, heads, spt;
        int unsigned      n;
        bit               in_range;
        in_range = (int'(sel) < NUM_PARTITIONS) && (rel < region_map[sel][63:32]);
        if (!in_range) begin
            // rejected start: one error result, address fields cleared
            r        = '0;
            r.status = 1'b1;
            r.last   = 1'b1;
            chs_due.push_back(r);
            return;
        end
        n        = (cnt > MAX_RUN) ? MAX_RUN : cnt;
        heads    = (heads_cfg == 0) ? 1 : heads_cfg;
        spt      = (spt_cfg == 0) ? 1 : spt_cfg;
        per_cyl  = heads * spt;
        base_lba = region_map[sel][31:0] + rel;
        for (int unsigned i = 0; i < n; i++) begin
            lba          = base_lba + i;    // wraps at 2^32
            r.cylinder   = CYL_W'(lba / per_cyl);
            r.head       = HEAD_W'((lba % per_cyl) / spt);
            r.sector_num = SEC_W'((lba % spt) + 1);
            r.status     = 1'b0;
            r.last       = (i + 1 == n);
            chs_due.push_back(r);
        end
    endfunction

    task automatic check_result();
        chs_result_t want;
        if (chs_due.size() == 0) begin
            note_mismatch("result with no request outstanding", 32'(res.cylinder), '0);
            return;
        end
        want = chs_due.pop_front();
        if (res.cylinder !== want.cylinder)
            note_mismatch("cylinder", 32'(res.cylinder), 32'(want.cylinder));
        if (res.head !== want.head)
            note_mismatch("head", 32'(res.head), 32'(want.head));
        if (res.sector_num !== want.sector_num)
            note_mismatch("sector_num", 32'(res.sector_num), 32'(want.sector_num));
        if (res.status !== want.status)
            note_mismatch("status", 32'(res.status), 32'(want.status));
        if (res.last !== want.last)
            note_mismatch("last", 32'(res.last), 32'(want.last));
    endtask

    // sample all three channels on the clock edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int p = 0; p < (1 << SEL_W); p++)
                region_map[p] = '0;
            heads_cfg = pbchs_pkg::HEADS_RESET;
            spt_cfg   = pbchs_pkg::SPT_RESET;
            chs_due.delete();
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                // indexes below the geometry registers are partition regions
                if (cfg.index < pbchs_pkg::REG_HEADS)
                    region_map[cfg.index[SEL_W-1:0]] = cfg.data;
                else if (cfg.index == pbchs_pkg::REG_HEADS)
                    heads_cfg = cfg.data[4:0];
                else if (cfg.index == pbchs_pkg::REG_SPT)
                    spt_cfg = cfg.data[7:0];
            end
            if (req.valid && req.ready)
                translate_run(req.partition_sel, req.rel_sector, req.sector_count);
            if (res.valid && res.ready)
                check_result();
        end
        due_cnt = chs_due.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the CHS translator: clock, reset, stimulus, flow control and verdict
module tb_top;

    // package constants used here
    localparam int CFG_IDX_W  = pbchs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = pbchs_pkg::CFG_DATA_W;
    localparam int SEL_W      = pbchs_pkg::SEL_W;
    localparam int ABS_W      = pbchs_pkg::ABS_W;
    localparam int COUNT_W    = pbchs_pkg::COUNT_W;

    localparam int     NUM_PARTS       = 4;
    localparam int     MAX_RUN_LEN     = 64;
    localparam int     CLK_HALF        = 10;
    localparam int     SETTLE_CYCLES   = 100;
    localparam int     LONG_HOLD       = 400;
    localparam int     RANDOM_PHASES   = 5;
    localparam int     ITEMS_PER_PHASE = 78;
    localparam longint LIMIT_NS        = 64'd40_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_PART0 = 3'd0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // register values this testbench has programmed
    logic [31:0] part_start_tb [NUM_PARTS];
    logic [31:0] part_len_tb   [NUM_PARTS];
    logic [4:0]  heads_tb;
    logic [7:0]  spt_tb;

    int unsigned idle_pct        = 0;
    bit          backpressure_on = 1'b0;
    bit          quiet_tail      = 1'b0;
    int unsigned due_cnt;
    int unsigned fail_cnt;

    pbchs_req_if req_ch ();
    pbchs_res_if res_ch ();
    pbchs_cfg_if cfg_ch ();

    partition_block_to_chs_core #(
        .NUM_PARTITIONS (NUM_PARTS),
        .MAX_RUN        (MAX_RUN_LEN)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    pbchs_chs_checker #(
        .NUM_PARTITIONS (NUM_PARTS),
        .MAX_RUN        (MAX_RUN_LEN)
    ) chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .cfg     (cfg_ch),
        .pending (due_cnt),
        .errors  (fail_cnt)
    );

    always #(CLK_HALF) clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side flow control: stretches of random stalls, one long hold-off
    initial
    begin : result_ready_gen
        int unsigned stall_pct, stretch, gap;
        bit          held;
        held      = 1'b0;
        stall_pct = 0;
        stretch   = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stretch == 0)
            begin
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
                stretch   = $urandom_range(20, 200);
            end
            stretch--;
            if (backpressure_on && !held)
            begin
                // long hold-off so the block backs up into its request side
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < stall_pct)
            begin
                gap = $urandom_range(1, 11);
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // one register write transaction; valid is left high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // write every register from the shadow values
    task automatic push_config();
        for (int p = 0; p < NUM_PARTS; p++)
            write_reg(REG_PART0 + CFG_IDX_W'(p), {part_len_tb[p], part_start_tb[p]});
        write_reg(pbchs_pkg::REG_HEADS, CFG_DATA_W'(heads_tb));
        write_reg(pbchs_pkg::REG_SPT, CFG_DATA_W'(spt_tb));
        cfg_ch.valid <= 1'b0;
    endtask

    // one request transaction, with an optional idle burst ahead of it
    task automatic send_req(input logic [SEL_W-1:0] sel, input logic [ABS_W-1:0] rel,
                            input logic [COUNT_W-1:0] cnt);
        if (!quiet_tail && !backpressure_on && $urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.partition_sel <= sel;
        req_ch.rel_sector    <= rel;
        req_ch.sector_count  <= cnt;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // wait for every owed result, then let a zero-count request finish inside the block
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (due_cnt != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_layout();
        int unsigned pick;
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            part_start_tb[p] = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                part_len_tb[p] = '0;
            else if (pick < 15)
                part_len_tb[p] = 32'hFFFF_FFFF;
            else if (pick < 50)
                part_len_tb[p] = $urandom;
            else
                part_len_tb[p] = $urandom_range(1, 4096);
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            heads_tb = '0;
        else if (pick < 15)
            heads_tb = 5'($urandom_range(17, 31));
        else
            heads_tb = 5'($urandom_range(1, 16));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            spt_tb = '0;
        else if (pick < 15)
            spt_tb = 8'd255;
        else
            spt_tb = 8'($urandom_range(1, 255));
    endtask

    // mostly in-range starts, with boundary hits and out-of-range noise
    task automatic random_request();
        logic [SEL_W-1:0]   sel;
        logic [ABS_W-1:0]   rel, len;
        logic [COUNT_W-1:0] cnt;
        int unsigned        pick;
        sel  = SEL_W'($urandom_range(0, NUM_PARTS - 1));
        len  = part_len_tb[sel];
        pick = $urandom_range(0, 99);
        if (len == 0 || pick < 10)
            rel = $urandom;
        else if (pick < 16)
            rel = len;
        else if (pick < 22)
            rel = len - 1;
        else
            rel = $urandom % len;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            cnt = '0;
        else if (pick < 10)
            cnt = COUNT_W'($urandom_range(MAX_RUN_LEN + 1, 127));
        else if (pick < 30)
            cnt = COUNT_W'($urandom_range(17, MAX_RUN_LEN));
        else
            cnt = COUNT_W'($urandom_range(1, 16));
        send_req(sel, rel, cnt);
    endtask

    initial
    begin : stimulus
        req_ch.valid         <= 1'b0;
        req_ch.partition_sel <= '0;
        req_ch.rel_sector    <= '0;
        req_ch.sector_count  <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            part_start_tb[p] = '0;
            part_len_tb[p]   = '0;
        end
        heads_tb = pbchs_pkg::HEADS_RESET;
        spt_tb   = pbchs_pkg::SPT_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 30;

        // reset layout: every partition is empty, so every start is rejected
        send_req(2'd0, 32'd0, 7'd1);
        send_req(2'd3, 32'hFFFF_FFFF, 7'd0);
        drain();

        // boundaries, address wrap, empty partition, zero and oversized counts
        part_start_tb[0] = 32'd0;         part_len_tb[0] = 32'd1000;
        part_start_tb[1] = 32'hFFFF_FFF0; part_len_tb[1] = 32'hFFFF_FFFF;
        part_start_tb[2] = 32'd12345;     part_len_tb[2] = 32'd0;
        part_start_tb[3] = 32'hA5A5_5A5A; part_len_tb[3] = 32'h8000_0000;
        heads_tb = 5'd16;
        spt_tb   = 8'd63;
        push_config();
        send_req(2'd0, 32'd0, 7'd1);
        send_req(2'd0, 32'd999, 7'd64);
        send_req(2'd0, 32'd1000, 7'd5);
        send_req(2'd0, 32'hFFFF_FFFF, 7'd1);
        send_req(2'd1, 32'h0000_000F, 7'd40);
        send_req(2'd1, 32'hFFFF_FFFE, 7'd3);
        send_req(2'd1, 32'hFFFF_FFFF, 7'd2);
        send_req(2'd2, 32'd0, 7'd1);
        send_req(2'd3, 32'h7FFF_FFFF, 7'd127);
        send_req(2'd3, 32'd5, 7'd0);
        send_req(2'd0, 32'd10, 7'd65);
        drain();

        // zero heads and zero sectors per track fall back to one
        heads_tb = 5'd0;
        spt_tb   = 8'd0;
        push_config();
        send_req(2'd3, 32'h0001_2345, 7'd8);
        send_req(2'd1, 32'h0000_0100, 7'd20);
        drain();

        // more than 16 heads: head number keeps its low bits
        heads_tb = 5'd31;
        spt_tb   = 8'd255;
        push_config();
        send_req(2'd3, 32'h5555_AAAA, 7'd64);
        send_req(2'd0, 32'd500, 7'd10);
        drain();

        // smallest real geometry
        heads_tb = 5'd1;
        spt_tb   = 8'd1;
        push_config();
        send_req(2'd1, 32'hFFFF_FFF0, 7'd17);
        send_req(2'd0, 32'd0, 7'd64);
        drain();

        // largest legal geometry
        heads_tb = 5'd16;
        spt_tb   = 8'd255;
        push_config();
        send_req(2'd3, 32'h7FFF_FFC0, 7'd64);
        send_req(2'd0, 32'd999, 7'd1);
        drain();

        // random layouts; one phase with a long result hold-off, the last with no idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_layout();
            push_config();
            backpressure_on = (ph == 1);
            quiet_tail      = (ph == RANDOM_PHASES - 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i % 20 == 0)
                    idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
                random_request();
            end
            drain();
            backpressure_on = 1'b0;
        end

        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
